// ===== sv/sbk_pkg.sv =====
// Shared types and constants for the shell sort by key block.
// Used by sbk_sorter and shell_sort_by_key; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbk_pkg;

   localparam int BYTE_BITS = 8;

   // Top level to sorter.
   typedef struct packed {
      logic start;
   } sort_ctl_type;

   // Sorter to top level.
   typedef struct packed {
      logic busy;
      logic done;
   } sort_sts_type;

endpackage

`default_nettype wire

// ===== sv/sbk_mem.sv =====
// Item store for the shell sort by key block: one write port and one
// registered read port. Depends on nothing else in the project.
`timescale 1ns / 1ps
`default_nettype none

module sbk_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 36
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== sv/sbk_sorter.sv =====
// Shell sort sequencer: halving gaps, compare-and-swap insertion walks,
// one shared key comparator over the one-read, one-write store. Uses sbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbk_sorter #(
   parameter int KEY_BITS  = 20,
   parameter int DW        = 36,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbk_pkg::sort_ctl_type ctl,
   output sbk_pkg::sort_sts_type      sts,
   input  wire logic [CW-1:0]         n,
   output logic                       mem_we,
   output logic      [AW-1:0]         mem_waddr,
   output logic      [DW-1:0]         mem_wdata,
   output logic      [AW-1:0]         mem_raddr,
   input  wire logic [DW-1:0]         mem_rdata
);
   import sbk_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OUTER,
      S_RD_LO,
      S_RD_HI,
      S_CMP,
      S_WR_HI
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] gap_ff, gap_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [DW-1:0] lo_ff, lo_in;
   logic          done_ff, done_in;
   logic [CW-1:0] j_hi;
   logic          swap;

   assign j_hi = j_ff + gap_ff;
   // the shared compare unit: earlier key strictly greater
   assign swap = lo_ff[KEY_BITS-1:0] > mem_rdata[KEY_BITS-1:0];

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      gap_in    = gap_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lo_in     = lo_ff;
      done_in   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = j_ff[AW-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = j_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               n_in     = n;
               gap_in   = n >> 1;
               i_in     = n >> 1;
               state_in = S_OUTER;
            end
         end
         S_OUTER: begin
            if (gap_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (i_ff >= n_ff) begin
               gap_in = gap_ff >> 1;
               i_in   = gap_ff >> 1;
            end else begin
               j_in     = i_ff - gap_ff;
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: begin
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            mem_raddr = j_hi[AW-1:0];
            lo_in     = mem_rdata;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (swap) begin
               mem_we   = 1'b1;
               state_in = S_WR_HI;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_OUTER;
            end
         end
         S_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = j_hi[AW-1:0];
            mem_wdata = lo_ff;
            if (j_ff < gap_ff) begin
               i_in     = i_ff + CW'(1);
               state_in = S_OUTER;
            end else begin
               j_in     = j_ff - gap_ff;
               state_in = S_RD_LO;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      gap_ff <= gap_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      lo_ff  <= lo_in;
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign sts.busy = (state_ff != S_IDLE);
   assign sts.done = done_ff;

   a_wr_in_batch: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) < n_ff))
      else $error("sorter writes outside the batch");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_LO) |-> (i_ff < n_ff && j_ff < i_ff && j_hi < n_ff))
      else $error("compare pair out of range");

   a_done_from_outer: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff) == S_OUTER && $past(gap_ff) == '0))
      else $error("sort done without the last gap finishing");

endmodule

`default_nettype wire

// ===== sv/shell_sort_by_key.sv =====
// Batch sorter of (key, handle) words by Shell's method. Words are stored one
// per cycle until the word marked tlast; words past MAX_ITEMS are dropped and
// the batch is flagged on tuser. The batch is then sorted ascending by key
// with gaps n/2, n/4 .. 1 and strict-greater compare-and-swap insertion walks,
// and emitted in order with tlast on the final word. Every access goes through
// one store with a single read and a single write port, so each compare reads
// the lower word, then the upper word, then compares the keys; each swap adds
// a step that writes the lower word up, and each insertion walk and each gap
// step is set up in its own state; each word is emitted by a read, a load into
// the output register and a wait for the sink. The block takes no input while
// it sorts or emits. Uses sbk_pkg, sbk_mem and sbk_sorter.
`timescale 1ns / 1ps
`default_nettype none

module shell_sort_by_key #(
   parameter int MAX_ITEMS   = 64,
   parameter int KEY_BITS    = 20,
   parameter int HANDLE_BITS = 16,
   localparam int TDW = ((KEY_BITS + HANDLE_BITS + sbk_pkg::BYTE_BITS - 1)
                         / sbk_pkg::BYTE_BITS) * sbk_pkg::BYTE_BITS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [TDW-1:0] req_tdata,   // net_key, pin_handle, zero pad
   input  wire logic           req_tlast,   // batch_last
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic      [TDW-1:0] rsp_tdata,   // sorted_key, sorted_handle, zero pad
   output logic                rsp_tlast,   // run_last
   output logic                rsp_tuser    // overflowed
);
   import sbk_pkg::*;

   localparam int DW = KEY_BITS + HANDLE_BITS;
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;

   sort_ctl_type  sort_ctl;
   sort_sts_type  sort_sts;
   logic          srt_we;
   logic [AW-1:0] srt_waddr, srt_raddr;
   logic [DW-1:0] srt_wdata;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;

   logic          req_accept;
   logic          room;
   logic          load_we;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign room       = count_ff < CW'(MAX_ITEMS);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_data_in    = rsp_data_ff;
      load_we        = 1'b0;
      sort_ctl.start = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (room) begin
                  load_we  = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  sort_ctl.start = 1'b1;
                  state_in       = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (sort_sts.done) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mem_rdata;
            rsp_last_in  = (k_ff + CW'(1)) == count_ff;
            state_in     = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // store port goes to the sorter while it runs
   always_comb begin
      if (state_ff == ST_SORT) begin
         mem_we    = srt_we;
         mem_waddr = srt_waddr;
         mem_wdata = srt_wdata;
         mem_raddr = srt_raddr;
      end else begin
         mem_we    = load_we;
         mem_waddr = count_ff[AW-1:0];
         mem_wdata = {req_tdata[DW-1:KEY_BITS], req_tdata[KEY_BITS-1:0]};
         mem_raddr = k_ff[AW-1:0];
      end
   end

   sbk_mem #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW),
      .DW    (DW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sbk_sorter #(
      .KEY_BITS  (KEY_BITS),
      .DW        (DW),
      .AW        (AW),
      .CW        (CW)
   ) u_sorter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sort_ctl),
      .sts       (sort_sts),
      .n         (count_in),
      .mem_we    (srt_we),
      .mem_waddr (srt_waddr),
      .mem_wdata (srt_wdata),
      .mem_raddr (srt_raddr),
      .mem_rdata (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDW'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = ovf_ff;

   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("item count past capacity");

   a_batch_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0 && !ovf_ff))
      else $error("batch state not cleared after final word");

   a_sorter_idle_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SORT) |-> (!srt_we && !sort_sts.busy))
      else $error("sorter active outside the sort phase");

endmodule

`default_nettype wire
